// ===== rtl/rdla_pkg.sv =====
// Shared types, codes and reset constants for the remote drive lease arming core.
package rdla_pkg;

    // Q2.14 unit value
    localparam logic signed [15:0] Q_ONE     = 16'sd16384;
    localparam logic signed [15:0] Q_NEG_ONE = -16'sd16384;

    // Configuration reset values
    localparam logic [13:0] DEADZONE_RESET = 14'd0;
    localparam logic [31:0] TTL_RESET      = 32'd1000;

    // Register indexes on the configuration port
    localparam logic REG_DEADZONE = 1'b0;
    localparam logic REG_TTL      = 1'b1;

    typedef enum logic [2:0] {
        OP_CLAIM   = 3'd0,
        OP_RELEASE = 3'd1,
        OP_ARM     = 3'd2,
        OP_DISARM  = 3'd3,
        OP_COMMAND = 3'd4,
        OP_EXPIRE  = 3'd5,
        OP_FAULT   = 3'd6,
        OP_REJECT  = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SESSION     = 3'd1,
        ST_ARGUMENT    = 3'd2,
        ST_NOT_ARMED   = 3'd3,
        ST_NOT_APPLIED = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        MODE_DISARMED = 3'd0,
        MODE_ARMED    = 3'd1,
        MODE_ACTIVE   = 3'd2,
        MODE_EXPIRED  = 3'd3,
        MODE_FAULT    = 3'd4
    } t_mode;

    // Live configuration
    typedef struct packed {
        logic [13:0] deadzone;
        logic [31:0] ttl;
    } t_cfg;

    // Request after classification by the front end
    typedef struct packed {
        t_op                op;
        logic [63:0]        session;
        logic               session_nz;
        logic [63:0]        now_ms;
        logic               range_ok;
        logic signed [15:0] fwd;
        logic signed [15:0] trn;
        logic               no_motion;
        logic               deadman;
    } t_item;

    // One result
    typedef struct packed {
        t_status            status;
        logic signed [15:0] fwd;
        logic signed [15:0] trn;
        logic               no_motion;
        logic               deadman;
        logic               command_valid;
        t_mode              mode;
    } t_result;

endpackage

// ===== rtl/rdla_cfg.sv =====
// APB-style configuration registers: deadzone and lease time to live.
module rdla_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output rdla_pkg::t_cfg     o_cfg
);

    logic [13:0] r_deadzone;
    logic [31:0] r_ttl;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // register writes, word index from address bit 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= rdla_pkg::DEADZONE_RESET;
            r_ttl      <= rdla_pkg::TTL_RESET;
        end else if (wr_en) begin
            if (paddr[2] == rdla_pkg::REG_DEADZONE) begin
                r_deadzone <= pwdata[13:0];
            end else begin
                r_ttl <= pwdata;
            end
        end
    end

    // read mux
    assign prdata = (paddr[2] == rdla_pkg::REG_TTL) ? r_ttl : {18'd0, r_deadzone};

    assign o_cfg.deadzone = r_deadzone;
    assign o_cfg.ttl      = r_ttl;

endmodule

// ===== rtl/rdla_front.sv =====
// Front end: range check, deadzone and intent flags for each incoming request.
module rdla_front (
    input  logic               [2:0]  i_operation,
    input  logic               [63:0] i_session,
    input  logic               [63:0] i_now_ms,
    input  logic signed        [15:0] i_forward_in,
    input  logic signed        [15:0] i_turn_in,
    input  logic                      i_deadman_in,
    input  rdla_pkg::t_cfg            i_cfg,
    output rdla_pkg::t_item           o_item
);

    logic [15:0]        fwd_mag;
    logic [15:0]        trn_mag;
    logic signed [15:0] fwd_dz;
    logic signed [15:0] trn_dz;
    logic               zi;

    // magnitudes; -32768 wraps to 32768 in 16 unsigned bits
    assign fwd_mag = i_forward_in[15] ? (~i_forward_in + 16'd1) : i_forward_in;
    assign trn_mag = i_turn_in[15]    ? (~i_turn_in + 16'd1)    : i_turn_in;

    // deadzone
    assign fwd_dz = (fwd_mag < {2'b00, i_cfg.deadzone}) ? 16'sd0 : i_forward_in;
    assign trn_dz = (trn_mag < {2'b00, i_cfg.deadzone}) ? 16'sd0 : i_turn_in;
    assign zi     = (fwd_dz == 16'sd0) && (trn_dz == 16'sd0);

    // classified request
    always_comb begin
        o_item.op          = rdla_pkg::t_op'(i_operation);
        o_item.session     = i_session;
        o_item.session_nz  = (i_session != 64'd0);
        o_item.now_ms      = i_now_ms;
        o_item.range_ok    = (i_forward_in >= rdla_pkg::Q_NEG_ONE) &&
                             (i_forward_in <= rdla_pkg::Q_ONE) &&
                             (i_turn_in >= rdla_pkg::Q_NEG_ONE) &&
                             (i_turn_in <= rdla_pkg::Q_ONE);
        o_item.fwd         = fwd_dz;
        o_item.trn         = trn_dz;
        o_item.no_motion   = zi;
        o_item.deadman     = i_deadman_in & ~zi;
    end

endmodule

// ===== rtl/rdla_queue.sv =====
// Two-entry queue between the front end and the back end.
module rdla_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rdla_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output rdla_pkg::t_item o_head
);

    rdla_pkg::t_item r_slot0;
    rdla_pkg::t_item r_slot1;
    logic [1:0]      r_count;
    logic [1:0]      n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_slot0;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // slot data, head in slot 0
    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            if (i_push && r_count == 2'd1) begin
                r_slot0 <= i_item;
            end else begin
                r_slot0 <= r_slot1;
            end
            if (i_push && r_count == 2'd2) begin
                r_slot1 <= i_item;
            end
        end else if (i_push) begin
            if (r_count == 2'd0) begin
                r_slot0 <= i_item;
            end else begin
                r_slot1 <= i_item;
            end
        end
    end

endmodule

// ===== rtl/rdla_back.sv =====
// Back end: session, arm and lease state, and the registered result.
module rdla_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rdla_pkg::t_cfg    i_cfg,
    input  logic              i_head_valid,
    input  rdla_pkg::t_item   i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rdla_pkg::t_result o_result
);

    logic              r_claimed;
    logic [63:0]       r_owner;
    logic              r_armed;
    logic              r_lease;
    logic [63:0]       r_last_renew;
    rdla_pkg::t_mode   r_mode;
    logic              r_out_valid;
    rdla_pkg::t_result r_result;

    logic              n_claimed;
    logic [63:0]       n_owner;
    logic              n_armed;
    logic              n_lease;
    logic [63:0]       n_last_renew;
    rdla_pkg::t_mode   n_mode;
    rdla_pkg::t_result n_result;

    logic              owner_match;
    logic              owns;
    logic [63:0]       elapsed;
    logic              expire_due;

    // take the head when the output register is free or draining
    assign o_pop = i_head_valid && (!r_out_valid || i_out_ready);

    assign owner_match = (r_owner == i_head.session);
    assign owns        = i_head.session_nz && r_claimed && owner_match;
    assign elapsed     = i_head.now_ms - r_last_renew;
    assign expire_due  = elapsed > {32'd0, i_cfg.ttl};

    // next state
    always_comb begin
        n_claimed    = r_claimed;
        n_owner      = r_owner;
        n_armed      = r_armed;
        n_lease      = r_lease;
        n_last_renew = r_last_renew;
        n_mode       = r_mode;
        unique case (i_head.op)
            rdla_pkg::OP_CLAIM: begin
                if (i_head.session_nz && !(r_claimed && !owner_match)) begin
                    n_claimed = 1'b1;
                    n_owner   = i_head.session;
                end
            end
            rdla_pkg::OP_RELEASE: begin
                if (r_claimed && owner_match) begin
                    n_claimed = 1'b0;
                    n_owner   = 64'd0;
                    n_armed   = 1'b0;
                    n_lease   = 1'b0;
                    if (r_mode != rdla_pkg::MODE_EXPIRED) begin
                        n_mode = rdla_pkg::MODE_DISARMED;
                    end
                end
            end
            rdla_pkg::OP_ARM: begin
                if (owns) begin
                    n_armed      = 1'b1;
                    n_lease      = 1'b1;
                    n_last_renew = i_head.now_ms;
                    n_mode       = rdla_pkg::MODE_ARMED;
                end
            end
            rdla_pkg::OP_DISARM: begin
                if (owns) begin
                    n_armed = 1'b0;
                    n_lease = 1'b0;
                    n_mode  = rdla_pkg::MODE_DISARMED;
                end
            end
            rdla_pkg::OP_COMMAND: begin
                if (i_head.range_ok && owns && r_armed) begin
                    n_last_renew = i_head.now_ms;
                    n_lease      = 1'b1;
                    n_mode       = i_head.deadman ? rdla_pkg::MODE_ACTIVE
                                                  : rdla_pkg::MODE_ARMED;
                end
            end
            rdla_pkg::OP_EXPIRE: begin
                if (r_armed && r_lease && expire_due) begin
                    n_armed = 1'b0;
                    n_lease = 1'b0;
                    n_mode  = rdla_pkg::MODE_EXPIRED;
                end
            end
            rdla_pkg::OP_FAULT: begin
                n_armed = 1'b0;
                n_lease = 1'b0;
                n_mode  = rdla_pkg::MODE_FAULT;
            end
            rdla_pkg::OP_REJECT: begin
                n_lease = 1'b0;
                if (r_armed) begin
                    n_mode = rdla_pkg::MODE_ARMED;
                end
            end
            default: begin
                n_lease = r_lease;
            end
        endcase
    end

    // result fields
    always_comb begin
        n_result               = '0;
        n_result.status        = rdla_pkg::ST_OK;
        n_result.mode          = n_mode;
        unique case (i_head.op)
            rdla_pkg::OP_CLAIM: begin
                if (!i_head.session_nz || (r_claimed && !owner_match)) begin
                    n_result.status = rdla_pkg::ST_NOT_APPLIED;
                end
            end
            rdla_pkg::OP_RELEASE: begin
                if (!r_claimed || !owner_match) begin
                    n_result.status = rdla_pkg::ST_NOT_APPLIED;
                end
            end
            rdla_pkg::OP_ARM, rdla_pkg::OP_DISARM: begin
                if (!owns) begin
                    n_result.status = rdla_pkg::ST_SESSION;
                end
            end
            rdla_pkg::OP_COMMAND: begin
                priority if (!i_head.range_ok) begin
                    n_result.status = rdla_pkg::ST_ARGUMENT;
                end else if (!owns) begin
                    n_result.status = rdla_pkg::ST_SESSION;
                end else if (!r_armed) begin
                    n_result.status = rdla_pkg::ST_NOT_ARMED;
                end else begin
                    n_result.fwd           = i_head.fwd;
                    n_result.trn           = i_head.trn;
                    n_result.no_motion     = i_head.no_motion;
                    n_result.deadman       = i_head.deadman;
                    n_result.command_valid = 1'b1;
                end
            end
            rdla_pkg::OP_EXPIRE: begin
                if (!r_armed || !r_lease || !expire_due) begin
                    n_result.status = rdla_pkg::ST_NOT_APPLIED;
                end
            end
            rdla_pkg::OP_FAULT, rdla_pkg::OP_REJECT: begin
                n_result.status = rdla_pkg::ST_OK;
            end
            default: begin
                n_result.status = rdla_pkg::ST_OK;
            end
        endcase
    end

    // state update on each executed request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_claimed    <= 1'b0;
            r_owner      <= 64'd0;
            r_armed      <= 1'b0;
            r_lease      <= 1'b0;
            r_last_renew <= 64'd0;
            r_mode       <= rdla_pkg::MODE_DISARMED;
        end else if (o_pop) begin
            r_claimed    <= n_claimed;
            r_owner      <= n_owner;
            r_armed      <= n_armed;
            r_lease      <= n_lease;
            r_last_renew <= n_last_renew;
            r_mode       <= n_mode;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule

// ===== rtl/remote_drive_lease_arming_core.sv =====
// Remote drive lease arming interlock: top level.
//
// Request channel (i_in_valid / o_in_ready) carries one event: operation, session,
// time stamp, two Q2.14 axes and the deadman bit. Result channel
// (o_out_valid / i_out_ready) returns exactly one result per event, in order.
// The front end classifies each request (axis range, deadzone, intent) and
// pushes it into a two-entry queue; the back end executes one request per
// cycle against the session/arm/lease state and loads a result register.
// Throughput: one request per cycle as long as results are taken each cycle.
// A request is registered in the queue before the back end registers its result.
// The back end's path (64-bit elapsed-time subtract and compare) sets the
// cycle. When the receiver stalls, the result register holds, the queue fills
// and o_in_ready drops once both entries are used.
// Reset (i_rst_n low, synchronous) empties the queue and result register,
// drops claim, arm and lease, sets mode to disarmed, deadzone to 0 and lease
// time to live to 1000 ms. Registers sit on the APB port at 0 and 4.
module remote_drive_lease_arming_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic        [2:0]  paddr,
    input  logic        [31:0] pwdata,
    output logic        [31:0] prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic        [2:0]  i_operation,
    input  logic        [63:0] i_session,
    input  logic        [63:0] i_now_ms,
    input  logic signed [15:0] i_forward_in,
    input  logic signed [15:0] i_turn_in,
    input  logic               i_deadman_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic        [2:0]  o_status,
    output logic signed [15:0] o_forward_out,
    output logic signed [15:0] o_turn_out,
    output logic               o_no_motion,
    output logic               o_deadman_out,
    output logic               o_command_valid,
    output logic        [2:0]  o_mode
);

    rdla_pkg::t_cfg    cfg;
    rdla_pkg::t_item   front_item;
    rdla_pkg::t_item   head_item;
    rdla_pkg::t_result result;
    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic              push;

    assign o_in_ready = ~q_full;
    assign push       = i_in_valid & ~q_full;

    rdla_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rdla_front u_front (
        .i_operation  (i_operation),
        .i_session    (i_session),
        .i_now_ms     (i_now_ms),
        .i_forward_in (i_forward_in),
        .i_turn_in    (i_turn_in),
        .i_deadman_in (i_deadman_in),
        .i_cfg        (cfg),
        .o_item       (front_item)
    );

    rdla_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (head_item)
    );

    rdla_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head_valid (q_valid),
        .i_head       (head_item),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (result)
    );

    // result fields to ports
    assign o_status        = result.status;
    assign o_forward_out   = result.fwd;
    assign o_turn_out      = result.trn;
    assign o_no_motion     = result.no_motion;
    assign o_deadman_out   = result.deadman;
    assign o_command_valid = result.command_valid;
    assign o_mode          = result.mode;

endmodule

// ===== rtl/rdla_checker.sv =====
// Port-level checks for the lease arming core, bound to the top level.
module rdla_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic        [2:0]  o_status,
    input logic signed [15:0] o_forward_out,
    input logic signed [15:0] o_turn_out,
    input logic               o_no_motion,
    input logic               o_deadman_out,
    input logic               o_command_valid,
    input logic        [2:0]  o_mode
);

    // reset empties the result register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a stalled result stays
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) && $stable(o_mode))
        else $error("stalled result dropped or changed");

    // an accepted command reports OK and an armed or active mode
    a_command_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_command_valid |->
            o_status == rdla_pkg::ST_OK &&
            (o_mode == rdla_pkg::MODE_ARMED || o_mode == rdla_pkg::MODE_ACTIVE))
        else $error("command accepted with wrong status or mode");

    // drive fields are quiet unless a command was accepted
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_command_valid |->
            o_forward_out == 16'sd0 && o_turn_out == 16'sd0 &&
            !o_no_motion && !o_deadman_out)
        else $error("drive fields set without accepted command");

    // deadman with motion always means active mode
    a_deadman_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_deadman_out |-> o_mode == rdla_pkg::MODE_ACTIVE && !o_no_motion)
        else $error("deadman reported outside active mode");

endmodule

bind remote_drive_lease_arming_core rdla_checker u_rdla_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_status        (o_status),
    .o_forward_out   (o_forward_out),
    .o_turn_out      (o_turn_out),
    .o_no_motion     (o_no_motion),
    .o_deadman_out   (o_deadman_out),
    .o_command_valid (o_command_valid),
    .o_mode          (o_mode)
);
